[rtl/core/hdac_pkg.sv]
// Shared types and constants for the HID descriptor application classifier.
// Used by hdac_parser and hid_descriptor_app_classifier; depends on nothing.
`default_nettype none

package hdac_pkg;

  // Parser phase within the descriptor byte stream.
  typedef enum logic [1:0] {
    PH_PREFIX   = 2'd0,
    PH_LONGSIZE = 2'd1,
    PH_SKIP     = 2'd2,
    PH_PAYLOAD  = 2'd3
  } phase_t;

  // What the item in progress does once its payload is complete.
  typedef enum logic [2:0] {
    KIND_OTHER = 3'd0,
    KIND_PAGE  = 3'd1,
    KIND_USAGE = 3'd2,
    KIND_COLL  = 3'd3,
    KIND_MAIN  = 3'd4
  } kind_t;

  localparam logic [7:0]  LONG_ITEM_PREFIX = 8'hFE;
  localparam logic [1:0]  TYPE_MAIN        = 2'd0;
  localparam logic [1:0]  TYPE_GLOBAL      = 2'd1;
  localparam logic [1:0]  TYPE_LOCAL       = 2'd2;
  localparam logic [1:0]  SIZE_CODE_FOUR   = 2'd3;
  localparam logic [3:0]  TAG_USAGE_PAGE   = 4'h0;
  localparam logic [3:0]  TAG_USAGE        = 4'h0;
  localparam logic [3:0]  TAG_COLLECTION   = 4'hA;
  localparam logic [31:0] COLL_APPLICATION = 32'h0000_0001;

  localparam int unsigned CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_TARGET_PAGE  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TARGET_USAGE = 8'd1;

  localparam logic [15:0] TARGET_PAGE_RESET  = 16'h0001;
  localparam logic [15:0] TARGET_USAGE_RESET = 16'h0005;

endpackage

`default_nettype wire

[rtl/core/hdac_parser.sv]
// Byte-serial HID report descriptor item parser with usage tracking.
// Depends on hdac_pkg for phase and item kind types and item codes.
`default_nettype none

module hdac_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        take,
  input  wire logic [7:0]  data,
  input  wire logic        last,
  input  wire logic [15:0] target_page,
  input  wire logic [15:0] target_use,
  output logic             found
);

  hdac_pkg::phase_t phase, phase_next;
  hdac_pkg::kind_t  item_kind, item_kind_next;
  logic [8:0]  bytes_left, bytes_left_next;
  logic [31:0] payload_word, payload_word_next;
  logic [1:0]  payload_slot, payload_slot_next;
  logic [15:0] current_page, current_page_next;
  logic [15:0] pending_use, pending_use_next;
  logic        found_flag, found_flag_next;
  logic        halted, halted_next;

  logic             do_finish;
  hdac_pkg::kind_t  fin_kind;
  hdac_pkg::kind_t  kind_dec;
  logic [31:0]      fin_word;
  logic [31:0]      merged_word;
  logic [2:0]       size;
  logic [8:0]       left_dec;

  always_comb begin
    if (data[3:2] == hdac_pkg::TYPE_GLOBAL && data[7:4] == hdac_pkg::TAG_USAGE_PAGE) begin
      kind_dec = hdac_pkg::KIND_PAGE;
    end else if (data[3:2] == hdac_pkg::TYPE_LOCAL && data[7:4] == hdac_pkg::TAG_USAGE) begin
      kind_dec = hdac_pkg::KIND_USAGE;
    end else if (data[3:2] == hdac_pkg::TYPE_MAIN &&
                 data[7:4] == hdac_pkg::TAG_COLLECTION) begin
      kind_dec = hdac_pkg::KIND_COLL;
    end else if (data[3:2] == hdac_pkg::TYPE_MAIN) begin
      kind_dec = hdac_pkg::KIND_MAIN;
    end else begin
      kind_dec = hdac_pkg::KIND_OTHER;
    end
  end

  assign size        = (data[1:0] == hdac_pkg::SIZE_CODE_FOUR) ? 3'd4 : {1'b0, data[1:0]};
  assign left_dec    = (bytes_left != 9'd0) ? (bytes_left - 9'd1) : 9'd0;
  assign merged_word = payload_word | ({24'd0, data} << {payload_slot, 3'b000});

  always_comb begin
    phase_next        = phase;
    item_kind_next    = item_kind;
    bytes_left_next   = bytes_left;
    payload_word_next = payload_word;
    payload_slot_next = payload_slot;
    current_page_next = current_page;
    pending_use_next  = pending_use;
    found_flag_next   = found_flag;
    halted_next       = halted;
    do_finish         = 1'b0;
    fin_kind          = item_kind;
    fin_word          = payload_word;

    if (take && !halted) begin
      case (phase)
        hdac_pkg::PH_PREFIX: begin
          if (data == hdac_pkg::LONG_ITEM_PREFIX) begin
            phase_next = hdac_pkg::PH_LONGSIZE;
          end else begin
            item_kind_next    = kind_dec;
            payload_word_next = 32'd0;
            payload_slot_next = 2'd0;
            bytes_left_next   = {6'd0, size};
            if (size == 3'd0) begin
              do_finish = 1'b1;
              fin_kind  = kind_dec;
              fin_word  = 32'd0;
            end else begin
              phase_next = hdac_pkg::PH_PAYLOAD;
            end
          end
        end
        hdac_pkg::PH_LONGSIZE: begin
          bytes_left_next = {1'b0, data} + 9'd1;
          phase_next      = hdac_pkg::PH_SKIP;
        end
        hdac_pkg::PH_SKIP: begin
          bytes_left_next = left_dec;
          if (left_dec == 9'd0) begin
            phase_next = hdac_pkg::PH_PREFIX;
          end
        end
        hdac_pkg::PH_PAYLOAD: begin
          payload_word_next = merged_word;
          payload_slot_next = payload_slot + 2'd1;
          bytes_left_next   = left_dec;
          if (left_dec == 9'd0) begin
            do_finish = 1'b1;
            fin_word  = merged_word;
          end
        end
        default: begin
          phase_next = hdac_pkg::PH_PREFIX;
        end
      endcase

      if (do_finish) begin
        case (fin_kind)
          hdac_pkg::KIND_PAGE: begin
            current_page_next = fin_word[15:0];
          end
          hdac_pkg::KIND_USAGE: begin
            pending_use_next = fin_word[15:0];
          end
          hdac_pkg::KIND_COLL: begin
            if (fin_word == hdac_pkg::COLL_APPLICATION && current_page == target_page &&
                pending_use == target_use) begin
              found_flag_next = 1'b1;
              halted_next     = 1'b1;
            end
            pending_use_next = 16'd0;
          end
          hdac_pkg::KIND_MAIN: begin
            pending_use_next = 16'd0;
          end
          default: begin
          end
        endcase
        phase_next      = hdac_pkg::PH_PREFIX;
        bytes_left_next = 9'd0;
      end
    end
  end

  // The result reflects the final byte itself; the state then restarts.
  assign found = found_flag_next;

  always_ff @(posedge clk) begin
    if (rst || (take && last)) begin
      phase        <= hdac_pkg::PH_PREFIX;
      item_kind    <= hdac_pkg::KIND_OTHER;
      bytes_left   <= 9'd0;
      payload_word <= 32'd0;
      payload_slot <= 2'd0;
      current_page <= 16'd0;
      pending_use  <= 16'd0;
      found_flag   <= 1'b0;
      halted       <= 1'b0;
    end else begin
      phase        <= phase_next;
      item_kind    <= item_kind_next;
      bytes_left   <= bytes_left_next;
      payload_word <= payload_word_next;
      payload_slot <= payload_slot_next;
      current_page <= current_page_next;
      pending_use  <= pending_use_next;
      found_flag   <= found_flag_next;
      halted       <= halted_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/hid_descriptor_app_classifier.sv]
// HID descriptor application classifier: one descriptor byte per cycle.
// The match result is registered and valid in the cycle after the last byte is accepted.
// Throughput: one byte per cycle; only a stalled, unread result holds input.
// Reset (rst, synchronous): parse state cleared, targets return to page 1, usage 5.
// Depends on hdac_pkg and hdac_parser.
`default_nettype none

module hid_descriptor_app_classifier (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [7:0]                       descriptor_byte,
  input  wire logic                             last_byte,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  matched,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [hdac_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [15:0]                      cfg_data
);

  logic [15:0] target_page;
  logic [15:0] target_use;
  logic        accept;
  logic        found;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_page <= hdac_pkg::TARGET_PAGE_RESET;
      target_use  <= hdac_pkg::TARGET_USAGE_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == hdac_pkg::REG_TARGET_PAGE) begin
        target_page <= cfg_data;
      end else if (cfg_index == hdac_pkg::REG_TARGET_USAGE) begin
        target_use <= cfg_data;
      end
    end
  end

  hdac_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .take        (accept),
    .data        (descriptor_byte),
    .last        (last_byte),
    .target_page (target_page),
    .target_use  (target_use),
    .found       (found)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_byte) begin
      matched <= found;
    end
  end

endmodule

`default_nettype wire
